// ===== design/rnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rnp_pkg
// Types, codes and character helpers for the radix number parser.
// ----------------------------------------------------------------------------
package rnp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic               well_formed;
  } out_item_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_mode_t;

  typedef enum logic [1:0] {
    PH_SPACE   = 2'd0,
    PH_PREFIX2 = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_STOP    = 2'd3
  } parse_phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [4:0] NO_DIGIT = 5'd16;
  localparam logic [1:0] RADIX_RESET = 2'd2;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic [4:0] radix_of(input radix_mode_t mode);
    logic [4:0] r;
    unique case (mode)
      RADIX_BIN: r = 5'd2;
      RADIX_OCT: r = 5'd8;
      RADIX_DEC: r = 5'd10;
      RADIX_HEX: r = 5'd16;
      default:   r = 5'd10;
    endcase
    return r;
  endfunction

  // Digit value in the radix, NO_DIGIT when the character is not a digit.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input radix_mode_t mode);
    logic [7:0] v;
    v = 8'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      v = c - CH_LA + 8'd10;
    end
    return (v[4:0] < radix_of(mode)) ? v[4:0] : NO_DIGIT;
  endfunction

endpackage

// ===== design/radix_number_parser.sv =====
// ----------------------------------------------------------------------------
// radix_number_parser
// The result of an accepted terminator appears on out_data in the next cycle.
// Throughput: one character per cycle while in_stall is low; the parse state
// and the result register are updated in the cycle the character is accepted.
// Reset: synchronous, active low; radix returns to decimal, parse state clears.
// Streams characters, skips blanks, checks prefix or sign, accumulates digits.
// ----------------------------------------------------------------------------
module radix_number_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rnp_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rnp_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);
  import rnp_pkg::*;

  radix_mode_t  radix_r;
  parse_phase_t phase_r, phase_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic         neg_r, neg_nxt;
  logic         seen_r, seen_nxt;
  logic         fail_r, fail_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r, out_data_nxt;

  logic         in_xfer;
  logic [7:0]   c;
  logic [4:0]   dval;
  logic [31:0]  acc_scaled;
  logic         failed;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign c         = in_data.char_code;
  assign dval      = digit_value(c, radix_r);

  always_comb begin
    unique case (radix_r)
      RADIX_BIN: acc_scaled = {acc_r[30:0], 1'b0};
      RADIX_OCT: acc_scaled = {acc_r[28:0], 3'b000};
      RADIX_DEC: acc_scaled = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
      RADIX_HEX: acc_scaled = {acc_r[27:0], 4'b0000};
      default:   acc_scaled = acc_r;
    endcase
  end

  assign failed = fail_r || (phase_r == PH_PREFIX2) ||
                  ((phase_r == PH_SPACE) && (radix_r != RADIX_DEC));

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_xfer) begin
      if (in_data.end_of_string) begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.parsed_value = failed ? 32'sd0 :
                                    (neg_r ? $signed(32'd0 - acc_r) : $signed(acc_r));
        out_data_nxt.well_formed  = !failed && seen_r && (phase_r == PH_DIGITS);
        phase_nxt = PH_SPACE;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        fail_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          PH_SPACE: begin
            if (!is_blank(c)) begin
              if (radix_r == RADIX_DEC) begin
                if (c == CH_MINUS || c == CH_PLUS) begin
                  neg_nxt   = (c == CH_MINUS);
                  phase_nxt = PH_DIGITS;
                end else if (dval != NO_DIGIT) begin
                  acc_nxt   = acc_scaled + {27'd0, dval};
                  seen_nxt  = 1'b1;
                  phase_nxt = PH_DIGITS;
                end else begin
                  phase_nxt = PH_STOP;
                end
              end else if (c != CH_ZERO) begin
                fail_nxt  = 1'b1;
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = (radix_r == RADIX_OCT) ? PH_DIGITS : PH_PREFIX2;
              end
            end
          end
          PH_PREFIX2: begin
            if ((radix_r == RADIX_BIN && (c == CH_LB || c == CH_UB)) ||
                (radix_r == RADIX_HEX && (c == CH_LX || c == CH_UX))) begin
              phase_nxt = PH_DIGITS;
            end else begin
              fail_nxt  = 1'b1;
              phase_nxt = PH_STOP;
            end
          end
          PH_DIGITS: begin
            if (dval != NO_DIGIT) begin
              acc_nxt  = acc_scaled + {27'd0, dval};
              seen_nxt = 1'b1;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_STOP: begin
            phase_nxt = PH_STOP;
          end
          default: begin
            phase_nxt = PH_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= radix_mode_t'(RADIX_RESET);
      phase_r     <= PH_SPACE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix_r <= radix_mode_t'(cfg_data);
      end
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      seen_r      <= seen_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
